@@ rtl/pur_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the phase reliability block
// no dependencies

package pur_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 12;

    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

endpackage

@@ rtl/pur_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual port ram, one write port, one registered read port
// no dependencies

module pur_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ rtl/pur_score.sv @@
`timescale 1ns / 1ps
// squares and sums four second differences into the reliability score
// depends on pur_pkg

module pur_score #(
    parameter int PHASE_BITS = 16,
    parameter int COL_W      = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [PHASE_BITS:0]          in_h,
    input  logic signed [PHASE_BITS:0]          in_v,
    input  logic signed [PHASE_BITS:0]          in_d1,
    input  logic signed [PHASE_BITS:0]          in_d2,
    input  logic [COL_W-1:0]                    in_col,
    input  logic [pur_pkg::ROW_W-1:0]           in_row,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2*PHASE_BITS+2:0]             out_reli,
    output logic [COL_W-1:0]                    out_col,
    output logic [pur_pkg::ROW_W-1:0]           out_row,
    output logic                                out_last
);

    localparam int SD_W   = PHASE_BITS + 1;
    localparam int SQ_W   = 2 * PHASE_BITS;
    localparam int PAIR_W = SQ_W + 1;
    localparam int SUM_W  = 2 * PHASE_BITS + 3;

    logic                        b_valid_reg, c_valid_reg, d_valid_reg, o_valid_reg;
    logic                        b_ready, c_ready, d_ready, o_ready;
    logic signed [SD_W-1:0]      b_sd_reg [4];
    logic [SQ_W-1:0]             c_sq_reg [4];
    logic [PAIR_W-1:0]           d_pair_reg [2];
    logic [SUM_W-1:0]            o_sum_reg;
    logic [COL_W-1:0]            b_col_reg, c_col_reg, d_col_reg, o_col_reg;
    logic [pur_pkg::ROW_W-1:0]   b_row_reg, c_row_reg, d_row_reg, o_row_reg;
    logic                        b_last_reg, c_last_reg, d_last_reg, o_last_reg;
    logic signed [2*SD_W-1:0]    prod [4];
    logic [PAIR_W-1:0]           pair_next [2];
    logic [SUM_W-1:0]            sum_next;

    assign o_ready  = !o_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || o_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod[i] = b_sd_reg[i] * b_sd_reg[i];
        end
        pair_next[0] = {1'b0, c_sq_reg[0]} + {1'b0, c_sq_reg[1]};
        pair_next[1] = {1'b0, c_sq_reg[2]} + {1'b0, c_sq_reg[3]};
        sum_next     = SUM_W'(d_pair_reg[0]) + SUM_W'(d_pair_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (b_ready) begin
                b_valid_reg <= in_valid;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
            if (o_ready) begin
                o_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && in_valid) begin
            b_sd_reg[0] <= in_h;
            b_sd_reg[1] <= in_v;
            b_sd_reg[2] <= in_d1;
            b_sd_reg[3] <= in_d2;
            b_col_reg   <= in_col;
            b_row_reg   <= in_row;
            b_last_reg  <= in_last;
        end
        if (c_ready && b_valid_reg) begin
            for (int i = 0; i < 4; i++) begin
                c_sq_reg[i] <= prod[i][SQ_W-1:0];
            end
            c_col_reg  <= b_col_reg;
            c_row_reg  <= b_row_reg;
            c_last_reg <= b_last_reg;
        end
        if (d_ready && c_valid_reg) begin
            d_pair_reg[0] <= pair_next[0];
            d_pair_reg[1] <= pair_next[1];
            d_col_reg     <= c_col_reg;
            d_row_reg     <= c_row_reg;
            d_last_reg    <= c_last_reg;
        end
        if (o_ready && d_valid_reg) begin
            o_sum_reg  <= sum_next;
            o_col_reg  <= d_col_reg;
            o_row_reg  <= d_row_reg;
            o_last_reg <= d_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_reli  = o_sum_reg;
    assign out_col   = o_col_reg;
    assign out_row   = o_row_reg;
    assign out_last  = o_last_reg;

endmodule

@@ rtl/phase_unwrap_reliability.sv @@
`timescale 1ns / 1ps
// top level: line buffers, 3x3 window and second difference reliability
// depends on pur_pkg, pur_ram, pur_score
//
//   channel  direction  handshake           payload
//   s_       in         s_tvalid/s_tready   s_tdata: phase
//   m_       out        m_tvalid/m_tready   m_tdata: reliability, center_col, center_row;
//                                            m_tlast: last
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one pixel per cycle sustained unless the output stalls; after its lower-right neighbour
// is taken, a result passes the line buffer read, second differences, squares, pair sums and
// final sum registers in that order. reset is synchronous; the line buffers are not cleared and
// need no clearing pass. a stalled output holds its register while the four-stage pipeline
// keeps filling its empty stages; border pixels never wait on it.

module phase_unwrap_reliability #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PHASE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PHASE_BITS+7)/8)*8-1:0]      s_tdata,   // phase
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*PHASE_BITS+3+$clog2(MAX_WIDTH)+12+7)/8)*8-1:0] m_tdata,
                                                 // reliability, center_col, center_row
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pur_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pur_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = pur_pkg::ROW_W;
    localparam int SD_W     = PHASE_BITS + 1;
    localparam int RELI_W   = 2 * PHASE_BITS + 3;
    localparam int OUT_BITS = RELI_W + COL_W + ROW_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int RESET_LAST_COL =
        ((MAX_WIDTH < pur_pkg::WIDTH_RESET) ? MAX_WIDTH : pur_pkg::WIDTH_RESET) - 1;
    localparam int RESET_LAST_ROW = pur_pkg::HEIGHT_RESET - 1;

    logic [COL_W-1:0]      last_col_reg, last_col_next;
    logic [ROW_W-1:0]      last_row_reg, last_row_next;
    logic [COL_W-1:0]      col_count_reg;
    logic [ROW_W-1:0]      row_count_reg;
    logic                  a_valid_reg;
    logic [PHASE_BITS-1:0] a_phase_reg;
    logic [COL_W-1:0]      a_col_reg;
    logic [ROW_W-1:0]      a_row_reg;
    logic [PHASE_BITS-1:0] win_reg [6];
    logic [PHASE_BITS-1:0] up_rd, mid_rd;
    logic                  s_accept, cfg_write, a_fire, a_interior;
    logic                  sc_ready, sc_valid, sc_last;
    logic signed [SD_W-1:0] sd_h, sd_v, sd_d1, sd_d2;
    logic [RELI_W-1:0]     sc_reli;
    logic [COL_W-1:0]      sc_col;
    logic [ROW_W-1:0]      sc_row;
    logic [pur_pkg::FW_W-1:0] fw;
    logic [pur_pkg::FH_W-1:0] fh;

    function automatic logic signed [SD_W-1:0] sec_diff(
        input logic [PHASE_BITS-1:0] a,
        input logic [PHASE_BITS-1:0] ce,
        input logic [PHASE_BITS-1:0] b
    );
        logic [PHASE_BITS-1:0] d1;
        logic [PHASE_BITS-1:0] d2;
        d1 = a - ce;
        d2 = ce - b;
        return {d1[PHASE_BITS-1], d1} - {d2[PHASE_BITS-1], d2};
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_accept  = s_tvalid && s_tready;

    // out-of-range sizes clamp on write
    always_comb begin
        fw = cfg_data[pur_pkg::FW_W-1:0];
        fh = cfg_data[pur_pkg::FH_W-1:0];
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_write && cfg_index == pur_pkg::REG_FRAME_WIDTH) begin
            priority if (32'(fw) < pur_pkg::MIN_DIM) begin
                last_col_next = COL_W'(pur_pkg::MIN_DIM - 1);
            end else if (32'(fw) > MAX_WIDTH) begin
                last_col_next = COL_W'(MAX_WIDTH - 1);
            end else begin
                last_col_next = COL_W'(fw - 1'b1);
            end
        end
        if (cfg_write && cfg_index == pur_pkg::REG_FRAME_HEIGHT) begin
            priority if (32'(fh) < pur_pkg::MIN_DIM) begin
                last_row_next = ROW_W'(pur_pkg::MIN_DIM - 1);
            end else if (32'(fh) > pur_pkg::HEIGHT_LIMIT) begin
                last_row_next = ROW_W'(pur_pkg::HEIGHT_LIMIT - 1);
            end else begin
                last_row_next = ROW_W'(fh - 1'b1);
            end
        end
    end

    assign a_interior = (a_row_reg >= ROW_W'(2)) && (a_col_reg >= COL_W'(2));
    assign a_fire     = a_valid_reg && (!a_interior || sc_ready);
    assign s_tready   = !a_valid_reg || a_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg  <= COL_W'(RESET_LAST_COL);
            last_row_reg  <= ROW_W'(RESET_LAST_ROW);
            col_count_reg <= '0;
            row_count_reg <= '0;
            a_valid_reg   <= 1'b0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            if (cfg_write && (cfg_index == pur_pkg::REG_FRAME_WIDTH ||
                              cfg_index == pur_pkg::REG_FRAME_HEIGHT)) begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end else if (s_accept) begin
                if (col_count_reg == last_col_reg) begin
                    col_count_reg <= '0;
                    row_count_reg <= (row_count_reg == last_row_reg) ? '0
                                                                     : row_count_reg + 1'b1;
                end else begin
                    col_count_reg <= col_count_reg + 1'b1;
                end
            end
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_phase_reg <= s_tdata[PHASE_BITS-1:0];
            a_col_reg   <= col_count_reg;
            a_row_reg   <= row_count_reg;
        end
        if (a_fire) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_rd;
            win_reg[4] <= mid_rd;
            win_reg[5] <= a_phase_reg;
        end
    end

    // window: 0 upleft, 1 left, 2 downleft, 3 up, 4 centre, 5 down
    assign sd_h  = sec_diff(win_reg[1], win_reg[4], mid_rd);
    assign sd_v  = sec_diff(win_reg[3], win_reg[4], win_reg[5]);
    assign sd_d1 = sec_diff(win_reg[0], win_reg[4], a_phase_reg);
    assign sd_d2 = sec_diff(up_rd, win_reg[4], win_reg[2]);

    pur_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .aclk  (aclk),
        .we    (a_fire),
        .waddr (a_col_reg),
        .wdata (mid_rd),
        .re    (s_accept),
        .raddr (col_count_reg),
        .rdata (up_rd)
    );

    pur_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .aclk  (aclk),
        .we    (a_fire),
        .waddr (a_col_reg),
        .wdata (a_phase_reg),
        .re    (s_accept),
        .raddr (col_count_reg),
        .rdata (mid_rd)
    );

    pur_score #(
        .PHASE_BITS (PHASE_BITS),
        .COL_W      (COL_W)
    ) u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg && a_interior),
        .in_ready  (sc_ready),
        .in_h      (sd_h),
        .in_v      (sd_v),
        .in_d1     (sd_d1),
        .in_d2     (sd_d2),
        .in_col    (a_col_reg - 1'b1),
        .in_row    (a_row_reg - 1'b1),
        .in_last   ((a_row_reg == last_row_reg) && (a_col_reg == last_col_reg)),
        .out_valid (sc_valid),
        .out_ready (m_tready),
        .out_reli  (sc_reli),
        .out_col   (sc_col),
        .out_row   (sc_row),
        .out_last  (sc_last)
    );

    assign m_tvalid = sc_valid;
    assign m_tdata  = OUT_W'({sc_row, sc_col, sc_reli});
    assign m_tlast  = sc_last;

    // line buffer write-back never lands on the address being read
    a_no_ram_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && a_fire) |-> (col_count_reg != a_col_reg))
        else $error("line buffer read and write collide");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_count_reg <= last_col_reg) && (row_count_reg <= last_row_reg))
        else $error("raster counter beyond frame size");

    a_stall_holds_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !a_fire) |=> ($stable(up_rd) && $stable(mid_rd)))
        else $error("line buffer data lost during stall");

endmodule

@@ test/tb_phase_unwrap_reliability.sv @@
`timescale 1ns / 1ps
// self-checking bench for phase_unwrap_reliability: drives a raster phase stream with random
// frame sizes and handshake gaps, predicts every window result and compares it field by field
// depends on pur_pkg and the rtl of phase_unwrap_reliability

module tb_phase_unwrap_reliability;

    localparam int MW          = 1024;
    localparam int PB          = 16;
    localparam int M_W         = ((2*PB + 3 + $clog2(MW) + 12 + 7) / 8) * 8;
    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 11;
    localparam int SETTLE_CYC  = 16;
    localparam int MAX_GAP     = 14;
    localparam int RESET_ITEMS = 40;
    localparam int RAND_ITEMS  = 830;
    localparam int WIDE_ITEMS  = 20;
    localparam int TALL_ITEMS  = 30;
    localparam int LIMIT       = 1500000;

    localparam pur_pkg::cfg_idx_t REG_SPARE_LO = 2'd2;
    localparam pur_pkg::cfg_idx_t REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [34:0] rel;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } rel_result_t;

    class reliability_board;
        int unsigned   w_reg;
        int unsigned   h_reg;
        logic [15:0]   upper[MW];
        logic [15:0]   middle[MW];
        logic [15:0]   win[6];
        int unsigned   col;
        int unsigned   row;
        rel_result_t   due_q[$];
        int unsigned   errors;
        int unsigned   n_samples;
        int unsigned   n_results;
        int unsigned   n_writes;

        function new();
            w_reg = pur_pkg::WIDTH_RESET;
            h_reg = pur_pkg::HEIGHT_RESET;
            foreach (upper[i]) begin
                upper[i]  = '0;
                middle[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col = 0;
            row = 0;
            errors = 0;
            n_samples = 0;
            n_results = 0;
            n_writes = 0;
        endfunction

        function int unsigned eff_width();
            if (w_reg < pur_pkg::MIN_DIM) return pur_pkg::MIN_DIM;
            if (w_reg > MW) return MW;
            return w_reg;
        endfunction

        function int unsigned eff_height();
            if (h_reg < pur_pkg::MIN_DIM) return pur_pkg::MIN_DIM;
            if (h_reg > pur_pkg::HEIGHT_LIMIT) return pur_pkg::HEIGHT_LIMIT;
            return h_reg;
        endfunction

        function longint wrap_diff(logic [15:0] a, logic [15:0] b);
            logic [15:0] d;
            d = a - b;
            return longint'(signed'(d));
        endfunction

        function void configure(pur_pkg::cfg_idx_t idx, logic [pur_pkg::CFG_DATA_W-1:0] v);
            n_writes++;
            if (idx == pur_pkg::REG_FRAME_WIDTH)
                w_reg = v[pur_pkg::FW_W-1:0];
            else if (idx == pur_pkg::REG_FRAME_HEIGHT)
                h_reg = v[pur_pkg::FH_W-1:0];
            else
                return;
            col = 0;
            row = 0;
        endfunction

        function void note_sample(logic [15:0] ph);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            logic [15:0] up;
            logic [15:0] mid;
            longint      dh;
            longint      dv;
            longint      d1;
            longint      d2;
            rel_result_t e;
            w = eff_width();
            h = eff_height();
            c = (col >= w) ? w - 1 : col;
            r = (row >= h) ? h - 1 : row;
            up  = upper[c];
            mid = middle[c];
            n_samples++;
            if (r >= 2 && c >= 2) begin
                dh = wrap_diff(win[1], win[4]) - wrap_diff(win[4], mid);
                dv = wrap_diff(win[3], win[4]) - wrap_diff(win[4], win[5]);
                d1 = wrap_diff(win[0], win[4]) - wrap_diff(win[4], ph);
                d2 = wrap_diff(up, win[4]) - wrap_diff(win[4], win[2]);
                e.rel  = 35'(dh*dh + dv*dv + d1*d1 + d2*d2);
                e.col  = 10'(c - 1);
                e.row  = 12'(r - 1);
                e.last = (r == h - 1) && (c == w - 1);
                due_q.push_back(e);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up;
            win[4] = mid;
            win[5] = ph;
            upper[c]  = mid;
            middle[c] = ph;
            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
                row = r;
            end
        endfunction

        function void check_result(logic [M_W-1:0] data, logic tl);
            rel_result_t e;
            logic [34:0] rel;
            logic [9:0]  c;
            logic [11:0] r;
            rel = data[34:0];
            c   = data[44:35];
            r   = data[56:45];
            n_results++;
            if (due_q.size() == 0) begin
                errors++;
                $error("unexpected result: reliability %0d col %0d row %0d last %0b",
                       rel, c, r, tl);
                return;
            end
            e = due_q.pop_front();
            if (rel !== e.rel) begin
                errors++;
                $error("reliability: expected %0d, actual %0d", e.rel, rel);
            end
            if (c !== e.col) begin
                errors++;
                $error("center_col: expected %0d, actual %0d", e.col, c);
            end
            if (r !== e.row) begin
                errors++;
                $error("center_row: expected %0d, actual %0d", e.row, r);
            end
            if (tl !== e.last) begin
                errors++;
                $error("last: expected %0b, actual %0b", e.last, tl);
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;    // phase
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [M_W-1:0]                 m_tdata;           // reliability, center_col, center_row
    logic                           m_tlast;           // last
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    pur_pkg::cfg_idx_t              cfg_index = pur_pkg::REG_FRAME_WIDTH;
    logic [pur_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    reliability_board board;
    bit               idle_on = 1'b1;
    int unsigned      stall_left = 0;
    int unsigned      rx_hold;
    int unsigned      cycles = 0;
    logic [15:0]      smooth_base = '0;

    phase_unwrap_reliability #(
        .MAX_WIDTH (MW),
        .PHASE_BITS(PB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("phase_unwrap_reliability verification failed");
            $finish;
        end
    end

    // result side with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tlast);
            rx_hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold != 0) begin
                m_tready   <= 1'b0;
                stall_left <= rx_hold;
            end
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_tready <= 1'b1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (idle_on && !m_tvalid && $urandom_range(0, 15) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, MAX_GAP);
        end
    end

    function automatic logic [15:0] draw_phase();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        if (sel <= 4) return 16'($urandom);
        smooth_base = smooth_base + 16'($urandom_range(0, 600)) - 16'd300;
        return smooth_base + 16'($urandom_range(0, 200));
    endfunction

    // one request per sample
    task automatic send_sample(input logic [15:0] ph);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ph;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(ph);
    endtask

    task automatic write_reg(input pur_pkg::cfg_idx_t idx,
                             input logic [pur_pkg::CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.configure(idx, v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drain the pipeline before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic logic [pur_pkg::CFG_DATA_W-1:0] draw_dim(input int unsigned hi);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return pur_pkg::CFG_DATA_W'($urandom_range(0, pur_pkg::MIN_DIM - 1));
        if (sel == 1) return pur_pkg::CFG_DATA_W'($urandom);
        return pur_pkg::CFG_DATA_W'($urandom_range(pur_pkg::MIN_DIM, hi));
    endfunction

    task automatic random_config();
        int unsigned kind;
        kind = $urandom_range(0, 2);
        if (kind != 2) write_reg(pur_pkg::REG_FRAME_WIDTH, draw_dim(10));
        if (kind != 1) write_reg(pur_pkg::REG_FRAME_HEIGHT, draw_dim(8));
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      pur_pkg::CFG_DATA_W'($urandom));
    endtask

    logic [15:0] corner_frames[27] = '{
        // largest second differences
        16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        // every neighbour exactly pi away
        16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        // small steps across the wrap point
        16'h7fff, 16'h8001, 16'h7fff, 16'h8001, 16'h8000, 16'h7fff, 16'h8001, 16'h7fff, 16'h8001
    };

    initial begin
        int unsigned rand_items;
        int unsigned n;
        int unsigned w;
        board = new();
        rand_items = 0;
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset dimensions: start of the first full-width row
        repeat (RESET_ITEMS) send_sample(draw_phase());

        settle();
        write_reg(pur_pkg::REG_FRAME_WIDTH, pur_pkg::CFG_DATA_W'(pur_pkg::MIN_DIM));
        write_reg(pur_pkg::REG_FRAME_HEIGHT, pur_pkg::CFG_DATA_W'(pur_pkg::MIN_DIM));
        foreach (corner_frames[i]) send_sample(corner_frames[i]);

        while (rand_items < RAND_ITEMS) begin
            settle();
            idle_on = ($urandom_range(0, 3) != 0);
            random_config();
            w = board.eff_width();
            n = w * board.eff_height() * $urandom_range(1, 2) + $urandom_range(0, 3 * w);
            if (n > 300) n = $urandom_range(50, 300);
            if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
            repeat (n) send_sample(draw_phase());
            rand_items += n;
        end

        // oversized width clamps to full width, then oversized height with clamped width
        settle();
        idle_on = 1'b0;
        write_reg(pur_pkg::REG_FRAME_WIDTH, pur_pkg::CFG_DATA_W'(2047));
        write_reg(pur_pkg::REG_FRAME_HEIGHT, pur_pkg::CFG_DATA_W'(pur_pkg::MIN_DIM));
        repeat (WIDE_ITEMS) send_sample(draw_phase());
        settle();
        write_reg(pur_pkg::REG_FRAME_WIDTH, pur_pkg::CFG_DATA_W'(0));
        write_reg(pur_pkg::REG_FRAME_HEIGHT, pur_pkg::CFG_DATA_W'(8191));
        repeat (TALL_ITEMS) send_sample(draw_phase());

        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (board.pending() != 0) board.errors++;

        $display("run covered %0d phase samples, %0d checked results, %0d register writes",
                 board.n_samples, board.n_results, board.n_writes);
        $display("frame sizes from the 3x3 minimum to clamped oversized ones, %0d errors",
                 board.errors);
        if (board.errors == 0) begin
            $display("phase_unwrap_reliability verification clean");
        end else begin
            $display("phase_unwrap_reliability verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/pur_pkg.sv
rtl/pur_ram.sv
rtl/pur_score.sv
rtl/phase_unwrap_reliability.sv
test/tb_phase_unwrap_reliability.sv
